// ===== hdl/lcdsmt_pkg.sv =====
// Shared types, register map and timing constants for the LCD scanline mode timer.
package lcdsmt_pkg;

  localparam int DOTS_PER_LINE   = 456;
  localparam int LINES_PER_FRAME = 154;
  localparam int VISIBLE_LINES   = 144;
  localparam int DRAW_DOTS       = 172;
  localparam int SCAN_DOTS       = 80;
  localparam int HBLANK_DOT      = SCAN_DOTS + DRAW_DOTS;
  localparam bit HBLANK_REACHED  = (HBLANK_DOT < DOTS_PER_LINE);

  localparam int DOT_W  = 9;
  localparam int LINE_W = 8;

  localparam logic [7:0] ENABLE_MASK  = 8'h80;
  localparam logic [7:0] SOURCES_MASK = 8'h78;

  localparam logic [15:0] ADDR_LCDC = 16'hFF40;
  localparam logic [15:0] ADDR_STAT = 16'hFF41;
  localparam logic [15:0] ADDR_SCY  = 16'hFF42;
  localparam logic [15:0] ADDR_SCX  = 16'hFF43;
  localparam logic [15:0] ADDR_LY   = 16'hFF44;
  localparam logic [15:0] ADDR_LYC  = 16'hFF45;
  localparam logic [15:0] ADDR_BGP  = 16'hFF47;
  localparam logic [15:0] ADDR_OBP0 = 16'hFF48;
  localparam logic [15:0] ADDR_OBP1 = 16'hFF49;

  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_SCAN   = 2'd2;
  localparam logic [1:0] MODE_DRAW   = 2'd3;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              vblank_irq;
    logic              stat_irq;
    logic              frame_done;
    logic [1:0]        current_mode;
    logic [LINE_W-1:0] current_line;
  } res_t;

  function automatic logic stat_hit(input logic match, input logic [1:0] mode,
                                    input logic [3:0] sources);
    stat_hit = (match && sources[3]) ||
               (mode == MODE_HBLANK && sources[0]) ||
               (mode == MODE_SCAN && sources[2]) ||
               (mode == MODE_VBLANK && sources[1]);
  endfunction

endpackage

// ===== hdl/lcd_scanline_mode_timer.sv =====
// Top level of the LCD scanline mode timer: handshake ports, timing core, result queue.
// Each result is registered in the result queue before it is presented on out_valid.
// Throughput: one item per cycle; a two-entry result queue keeps in_ready high while
// one result waits, so input stalls only when two results are held.
// Reset (rst_n low, synchronous): counters, mode, flags and all LCD registers clear to 0
// and the result queue empties.
module lcd_scanline_mode_timer import lcdsmt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic        in_stat_pending,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_vblank_irq,
  output logic        out_stat_irq,
  output logic        out_frame_done,
  output logic [1:0]  out_current_mode,
  output logic [7:0]  out_current_line
);

  logic fire;
  logic can_push;
  res_t step_res;
  res_t head;

  assign in_ready = can_push;
  assign fire     = in_valid && can_push;

  lcdsmt_timing u_timing (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .op           (in_op),
    .address      (in_address),
    .write_data   (in_write_data),
    .stat_pending (in_stat_pending),
    .res          (step_res)
  );

  lcdsmt_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .push_data (step_res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (head)
  );

  assign out_read_data    = head.read_data;
  assign out_vblank_irq   = head.vblank_irq;
  assign out_stat_irq     = head.stat_irq;
  assign out_frame_done   = head.frame_done;
  assign out_current_mode = head.current_mode;
  assign out_current_line = head.current_line;

endmodule

// ===== hdl/lcdsmt_timing.sv =====
// LCD register file, dot/line counters, mode sequencing and interrupt requests.
module lcdsmt_timing import lcdsmt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [1:0]  op,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic        stat_pending,
  output res_t        res
);

  logic [DOT_W-1:0]  dot_r, dot_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic              match_r, match_nxt;
  logic [7:0]        lcdc_r, lcdc_nxt;
  logic [3:0]        src_r, src_nxt;
  logic [7:0]        scy_r, scy_nxt;
  logic [7:0]        scx_r, scx_nxt;
  logic [7:0]        lyc_r, lyc_nxt;
  logic [7:0]        bgp_r, bgp_nxt;
  logic [7:0]        obp0_r, obp0_nxt;
  logic [7:0]        obp1_r, obp1_nxt;

  logic [DOT_W:0]    dot_inc;
  logic [LINE_W-1:0] line_inc;
  logic [7:0]        rd;
  logic              vblank, stat, frame;
  logic              match_new;

  always_comb begin
    dot_nxt   = dot_r;
    line_nxt  = line_r;
    mode_nxt  = mode_r;
    match_nxt = match_r;
    lcdc_nxt  = lcdc_r;
    src_nxt   = src_r;
    scy_nxt   = scy_r;
    scx_nxt   = scx_r;
    lyc_nxt   = lyc_r;
    bgp_nxt   = bgp_r;
    obp0_nxt  = obp0_r;
    obp1_nxt  = obp1_r;
    rd        = 8'd0;
    vblank    = 1'b0;
    stat      = 1'b0;
    frame     = 1'b0;
    dot_inc   = {1'b0, dot_r} + (DOT_W+1)'(1);
    line_inc  = line_r + LINE_W'(1);
    match_new = 1'b0;

    unique case (op_t'(op))
      OP_READ: begin
        unique case (address)
          ADDR_LCDC: rd = lcdc_r;
          ADDR_STAT: rd = {1'b1, src_r, match_r, mode_r};
          ADDR_SCY:  rd = scy_r;
          ADDR_SCX:  rd = scx_r;
          ADDR_LY: begin
            if ((lcdc_r & ENABLE_MASK) == 8'd0) begin
              line_nxt = '0;
              rd = 8'd0;
            end else begin
              rd = line_r;
            end
          end
          ADDR_LYC:  rd = lyc_r;
          ADDR_BGP:  rd = bgp_r;
          ADDR_OBP0: rd = obp0_r;
          ADDR_OBP1: rd = obp1_r;
          default:   rd = 8'd0;
        endcase
      end
      OP_WRITE: begin
        unique case (address)
          ADDR_LCDC: begin
            lcdc_nxt = write_data;
            if ((write_data & ENABLE_MASK) != 8'd0) mode_nxt = MODE_SCAN;
          end
          ADDR_STAT: src_nxt = write_data[6:3];
          ADDR_SCY:  scy_nxt = write_data;
          ADDR_SCX:  scx_nxt = write_data;
          ADDR_LYC: begin
            lyc_nxt   = write_data;
            match_new = (write_data == line_r);
            match_nxt = match_new;
            stat      = !stat_pending && stat_hit(match_new, mode_r, src_r);
          end
          ADDR_BGP:  bgp_nxt  = write_data;
          ADDR_OBP0: obp0_nxt = write_data;
          ADDR_OBP1: obp1_nxt = write_data;
          default: ;
        endcase
      end
      OP_TICK: begin
        if ((lcdc_r & ENABLE_MASK) != 8'd0) begin
          if (line_r < LINE_W'(VISIBLE_LINES)) begin
            if (dot_r == '0) begin
              match_new = (lyc_r == line_r);
              match_nxt = match_new;
              stat      = !stat_pending && stat_hit(match_new, mode_r, src_r);
              mode_nxt  = MODE_SCAN;
            end
            if (dot_r == DOT_W'(SCAN_DOTS)) mode_nxt = MODE_DRAW;
            if (HBLANK_REACHED && dot_r == DOT_W'(HBLANK_DOT)) mode_nxt = MODE_HBLANK;
          end else if (line_r == LINE_W'(VISIBLE_LINES) && dot_r == '0) begin
            mode_nxt = MODE_VBLANK;
            vblank   = 1'b1;
          end
          if (dot_inc >= (DOT_W+1)'(DOTS_PER_LINE)) begin
            dot_nxt = '0;
            if (line_inc >= LINE_W'(LINES_PER_FRAME)) begin
              line_nxt = '0;
              frame    = 1'b1;
            end else begin
              line_nxt = line_inc;
            end
          end else begin
            dot_nxt = dot_inc[DOT_W-1:0];
          end
        end
      end
      default: ;
    endcase

    res.read_data    = rd;
    res.vblank_irq   = vblank;
    res.stat_irq     = stat;
    res.frame_done   = frame;
    res.current_mode = mode_nxt;
    res.current_line = line_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r   <= '0;
      line_r  <= '0;
      mode_r  <= MODE_HBLANK;
      match_r <= 1'b0;
      lcdc_r  <= 8'd0;
      src_r   <= 4'd0;
      scy_r   <= 8'd0;
      scx_r   <= 8'd0;
      lyc_r   <= 8'd0;
      bgp_r   <= 8'd0;
      obp0_r  <= 8'd0;
      obp1_r  <= 8'd0;
    end else if (fire) begin
      dot_r   <= dot_nxt;
      line_r  <= line_nxt;
      mode_r  <= mode_nxt;
      match_r <= match_nxt;
      lcdc_r  <= lcdc_nxt;
      src_r   <= src_nxt;
      scy_r   <= scy_nxt;
      scx_r   <= scx_nxt;
      lyc_r   <= lyc_nxt;
      bgp_r   <= bgp_nxt;
      obp0_r  <= obp0_nxt;
      obp1_r  <= obp1_nxt;
    end
  end

  a_dot_range: assert property (@(posedge clk) disable iff (!rst_n)
    dot_r < DOT_W'(DOTS_PER_LINE))
    else $error("dot counter out of range");

  a_draw_window: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_DRAW |-> line_r < LINE_W'(VISIBLE_LINES) &&
      dot_r > DOT_W'(SCAN_DOTS) && dot_r <= DOT_W'(HBLANK_DOT))
    else $error("draw mode outside its window");

  a_stat_gated: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.stat_irq |-> !stat_pending)
    else $error("stat request while one is pending");

  a_frame_line0: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.frame_done |=> line_r == '0 && dot_r == '0)
    else $error("frame wrap left counters nonzero");

endmodule

// ===== hdl/lcdsmt_out_buf.sv =====
// Two-entry result queue: output register plus skid register.
module lcdsmt_out_buf import lcdsmt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic can_push,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic out_valid_r, skid_valid_r;
  res_t out_r, skid_r;

  assign can_push  = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= push_data;
      end
    end else if (push) begin
      skid_r <= push_data;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without output entry");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("push into full queue");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_ready |=> !skid_valid_r && out_valid_r)
    else $error("skid entry not moved forward");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the LCD scanline mode timer: directed register steps, then random traffic.
module tb;
  import lcdsmt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int MAX_GAP = 20;
  localparam int N_SCRIPT = 25;
  localparam int N_MIXED = 800;
  localparam int N_SWEEP = 522;
  localparam int CYCLE_LIMIT = (N_SCRIPT + N_MIXED + N_SWEEP + 3) * (2 * MAX_GAP + 4) * 3;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        pend;
    logic        known;
    res_t        want;
  } script_row_t;

  localparam res_t ZERO_RES = '0;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = OP_TICK;
  logic [15:0] in_address = '0;
  logic [7:0]  in_write_data = '0;
  logic        in_stat_pending = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_vblank_irq;
  logic        out_stat_irq;
  logic        out_frame_done;
  logic [1:0]  out_current_mode;
  logic [7:0]  out_current_line;

  // timer state as predicted
  logic [8:0] lcd_dot = '0;
  logic [7:0] lcd_line = '0;
  logic [1:0] lcd_mode = MODE_HBLANK;
  logic       lcd_match = 1'b0;
  logic [7:0] lcd_ctrl = '0;
  logic [3:0] lcd_sources = '0;
  logic [7:0] lcd_scy = '0;
  logic [7:0] lcd_scx = '0;
  logic [7:0] lcd_lyc = '0;
  logic [7:0] lcd_bgp = '0;
  logic [7:0] lcd_obp0 = '0;
  logic [7:0] lcd_obp1 = '0;

  res_t due_results[$];
  int   mismatches = 0;
  int   cycles = 0;
  int   sink_hold = 0;
  bit   quiet = 1'b0;

  script_row_t script [N_SCRIPT] = '{
    '{OP_READ,  ADDR_LCDC, 8'h00, 1'b0, 1'b1, ZERO_RES},
    '{OP_READ,  ADDR_STAT, 8'h00, 1'b0, 1'b1, '{8'h80, 1'b0, 1'b0, 1'b0, MODE_HBLANK, 8'd0}},
    '{OP_READ,  ADDR_LY,   8'h00, 1'b0, 1'b1, ZERO_RES},
    '{OP_READ,  ADDR_LYC,  8'h00, 1'b0, 1'b1, ZERO_RES},
    '{OP_TICK,  ADDR_LCDC, 8'h00, 1'b0, 1'b1, ZERO_RES},
    '{OP_NOP,   ADDR_LCDC, 8'hFF, 1'b1, 1'b1, ZERO_RES},
    '{OP_WRITE, ADDR_SCY,  8'hFF, 1'b0, 1'b1, ZERO_RES},
    '{OP_READ,  ADDR_SCY,  8'h00, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b0, MODE_HBLANK, 8'd0}},
    '{OP_WRITE, ADDR_BGP,  8'hFF, 1'b0, 1'b1, ZERO_RES},
    '{OP_READ,  ADDR_BGP,  8'h00, 1'b0, 1'b1, '{8'hFF, 1'b0, 1'b0, 1'b0, MODE_HBLANK, 8'd0}},
    '{OP_WRITE, ADDR_STAT, 8'hFF, 1'b0, 1'b1, ZERO_RES},
    '{OP_READ,  ADDR_STAT, 8'h00, 1'b0, 1'b1, '{8'hF8, 1'b0, 1'b0, 1'b0, MODE_HBLANK, 8'd0}},
    '{OP_WRITE, ADDR_LYC,  8'h00, 1'b1, 1'b1, ZERO_RES},
    '{OP_WRITE, ADDR_LYC,  8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, MODE_HBLANK, 8'd0}},
    '{OP_READ,  ADDR_STAT, 8'h00, 1'b0, 1'b1, '{8'hFC, 1'b0, 1'b0, 1'b0, MODE_HBLANK, 8'd0}},
    '{OP_WRITE, ADDR_LYC,  8'hFF, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, MODE_HBLANK, 8'd0}},
    '{OP_WRITE, ADDR_LY,   8'h55, 1'b0, 1'b1, ZERO_RES},
    '{OP_WRITE, ADDR_LYC + 16'd1, 8'hFF, 1'b0, 1'b1, ZERO_RES},
    '{OP_READ,  16'hFFFF,  8'h00, 1'b0, 1'b1, ZERO_RES},
    '{OP_READ,  16'h0000,  8'h00, 1'b0, 1'b1, ZERO_RES},
    '{OP_READ,  ADDR_OBP1 + 16'd1, 8'h00, 1'b0, 1'b1, ZERO_RES},
    '{OP_WRITE, ADDR_LCDC, 8'h91, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0, MODE_SCAN, 8'd0}},
    '{OP_TICK,  ADDR_LCDC, 8'h00, 1'b0, 1'b0, ZERO_RES},
    '{OP_TICK,  ADDR_LCDC, 8'h00, 1'b1, 1'b0, ZERO_RES},
    '{OP_READ,  ADDR_LY,   8'h00, 1'b0, 1'b0, ZERO_RES}
  };

  lcd_scanline_mode_timer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_address       (in_address),
    .in_write_data    (in_write_data),
    .in_stat_pending  (in_stat_pending),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_data    (out_read_data),
    .out_vblank_irq   (out_vblank_irq),
    .out_stat_irq     (out_stat_irq),
    .out_frame_done   (out_frame_done),
    .out_current_mode (out_current_mode),
    .out_current_line (out_current_line)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (quiet || roll < 70) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(MAX_GAP, 8);
  endfunction

  function automatic logic stat_due(input logic pend);
    return !pend && ((lcd_match && lcd_sources[3]) ||
                     (lcd_mode == MODE_HBLANK && lcd_sources[0]) ||
                     (lcd_mode == MODE_VBLANK && lcd_sources[1]) ||
                     (lcd_mode == MODE_SCAN && lcd_sources[2]));
  endfunction

  task automatic lcd_timing_step(input logic [1:0] op, input logic [15:0] addr,
                                 input logic [7:0] data, input logic pend, output res_t r);
    r = '0;
    case (op)
      OP_READ: begin
        case (addr)
          ADDR_LCDC: r.read_data = lcd_ctrl;
          ADDR_STAT: r.read_data = {1'b1, lcd_sources, lcd_match, lcd_mode};
          ADDR_SCY:  r.read_data = lcd_scy;
          ADDR_SCX:  r.read_data = lcd_scx;
          ADDR_LY: begin
            if ((lcd_ctrl & ENABLE_MASK) == 0) lcd_line = '0;
            r.read_data = lcd_line;
          end
          ADDR_LYC:  r.read_data = lcd_lyc;
          ADDR_BGP:  r.read_data = lcd_bgp;
          ADDR_OBP0: r.read_data = lcd_obp0;
          ADDR_OBP1: r.read_data = lcd_obp1;
          default:   r.read_data = '0;
        endcase
      end
      OP_WRITE: begin
        case (addr)
          ADDR_LCDC: begin
            lcd_ctrl = data;
            if ((data & ENABLE_MASK) != 0) lcd_mode = MODE_SCAN;
          end
          ADDR_STAT: lcd_sources = 4'((data & SOURCES_MASK) >> 3);
          ADDR_SCY:  lcd_scy = data;
          ADDR_SCX:  lcd_scx = data;
          ADDR_LYC: begin
            lcd_lyc = data;
            lcd_match = (lcd_lyc == lcd_line);
            r.stat_irq = stat_due(pend);
          end
          ADDR_BGP:  lcd_bgp = data;
          ADDR_OBP0: lcd_obp0 = data;
          ADDR_OBP1: lcd_obp1 = data;
          default: ;
        endcase
      end
      OP_TICK: begin
        if ((lcd_ctrl & ENABLE_MASK) != 0) begin
          if (lcd_line < VISIBLE_LINES) begin
            if (lcd_dot == 0) begin
              lcd_match = (lcd_lyc == lcd_line);
              r.stat_irq = stat_due(pend);
              lcd_mode = MODE_SCAN;
            end
            if (lcd_dot == SCAN_DOTS) lcd_mode = MODE_DRAW;
            if (lcd_dot == HBLANK_DOT && HBLANK_DOT < DOTS_PER_LINE) lcd_mode = MODE_HBLANK;
          end else if (lcd_line == VISIBLE_LINES && lcd_dot == 0) begin
            lcd_mode = MODE_VBLANK;
            r.vblank_irq = 1'b1;
          end
          if (lcd_dot == DOTS_PER_LINE - 1) begin
            lcd_dot = '0;
            if (lcd_line >= LINES_PER_FRAME - 1) begin
              lcd_line = '0;
              r.frame_done = 1'b1;
            end else begin
              lcd_line = lcd_line + 8'd1;
            end
          end else begin
            lcd_dot = lcd_dot + 9'd1;
          end
        end
      end
      default: ;
    endcase
    r.current_mode = lcd_mode;
    r.current_line = lcd_line;
  endtask

  task automatic drive_item(input logic [1:0] op, input logic [15:0] addr,
                            input logic [7:0] data, input logic pend,
                            input logic known, input res_t want);
    int gap;
    res_t r;
    if ($urandom_range(299) == 0) quiet = !quiet;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_address <= addr;
    in_write_data <= data;
    in_stat_pending <= pend;
    do @(posedge clk); while (!in_ready);
    lcd_timing_step(op, addr, data, pend, r);
    due_results.push_back(known ? want : r);
  endtask

  task automatic random_item(input int tick_pct);
    int roll;
    logic [1:0] op;
    logic [15:0] addr;
    logic [7:0] data;
    logic pend;
    roll = $urandom_range(99);
    if (roll < tick_pct) begin
      op = OP_TICK;
    end else begin
      roll = $urandom_range(19);
      op = (roll == 0) ? OP_NOP : (roll < 9) ? OP_READ : OP_WRITE;
    end
    if ($urandom_range(9) == 0) addr = 16'($urandom);
    else addr = 16'($urandom_range(ADDR_OBP1 + 16'd1, ADDR_LCDC));
    data = 8'($urandom);
    pend = ($urandom_range(9) < 3);
    // keep the display running most of the time, always during the tick sweep
    if (op == OP_WRITE && addr == ADDR_LCDC && (tick_pct > 90 || $urandom_range(9) != 0))
      data[7] = 1'b1;
    if (op == OP_WRITE && addr == ADDR_LYC && $urandom_range(1) == 1)
      data = 8'(lcd_line + 8'($urandom_range(1)));
    drive_item(op, addr, data, pend, 1'b0, ZERO_RES);
  endtask

  always @(posedge clk) begin
    if (sink_hold > 0) begin
      out_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      out_ready <= 1'b1;
      sink_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        $error("result item with no expectation pending");
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (out_read_data !== want.read_data) begin
          $error("read_data expected %0h actual %0h", want.read_data, out_read_data);
          mismatches++;
        end
        if (out_vblank_irq !== want.vblank_irq) begin
          $error("vblank_irq expected %0b actual %0b", want.vblank_irq, out_vblank_irq);
          mismatches++;
        end
        if (out_stat_irq !== want.stat_irq) begin
          $error("stat_irq expected %0b actual %0b", want.stat_irq, out_stat_irq);
          mismatches++;
        end
        if (out_frame_done !== want.frame_done) begin
          $error("frame_done expected %0b actual %0b", want.frame_done, out_frame_done);
          mismatches++;
        end
        if (out_current_mode !== want.current_mode) begin
          $error("current_mode expected %0d actual %0d", want.current_mode, out_current_mode);
          mismatches++;
        end
        if (out_current_line !== want.current_line) begin
          $error("current_line expected %0d actual %0d", want.current_line, out_current_line);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("lcd_scanline_mode_timer verification failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_SCRIPT; i++)
      drive_item(script[i].op, script[i].addr, script[i].data, script[i].pend,
                 script[i].known, script[i].want);

    for (int i = 0; i < N_MIXED; i++)
      random_item(60);

    // restart from line 0 and tick through the draw window and a line boundary
    drive_item(OP_WRITE, ADDR_LCDC, 8'h00, 1'b0, 1'b0, ZERO_RES);
    drive_item(OP_READ, ADDR_LY, 8'h00, 1'b0, 1'b0, ZERO_RES);
    drive_item(OP_WRITE, ADDR_LCDC, ENABLE_MASK | 8'($urandom), 1'b0, 1'b0, ZERO_RES);
    for (int i = 0; i < N_SWEEP; i++)
      random_item(98);

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("lcd_scanline_mode_timer verification clean");
    end else begin
      $display("lcd_scanline_mode_timer verification failed");
    end
    $finish;
  end

endmodule
